>>> rtl/core/dersig_pkg.sv
`default_nettype none
package dersig_pkg;

    localparam int ORDER_BYTES = 32;

    localparam logic [255:0] ORDER_N =
        256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_BAAEDCE6_AF48A03B_BFD25E8C_D0364141;
    localparam logic [255:0] HALF_N = ORDER_N >> 1;

    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_INTEGER  = 8'h02;
    localparam int         MIN_SIG_BYTES = 8;

    typedef logic [1:0] t_verdict;

    localparam t_verdict VERDICT_REJECT = 2'd0;
    localparam t_verdict VERDICT_HIGH_S = 2'd1;
    localparam t_verdict VERDICT_LOW_S  = 2'd2;

    typedef struct packed {
        logic [7:0] sig_byte;
        logic       last_byte;
    } t_byte_word;

    // byte of n with rem bytes left to go (rem = 1 is the lowest byte)
    function automatic logic [7:0] order_byte(input logic [5:0] rem);
        logic [4:0] k;
        k = rem[4:0] - 5'd1;
        if (rem == 6'd0 || rem > 6'(ORDER_BYTES)) begin
            return 8'h00;
        end
        return ORDER_N[{k, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] half_byte(input logic [5:0] rem);
        logic [4:0] k;
        k = rem[4:0] - 5'd1;
        if (rem == 6'd0 || rem > 6'(ORDER_BYTES)) begin
            return 8'h00;
        end
        return HALF_N[{k, 3'b000} +: 8];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/dersig_byte_if.sv
`default_nettype none
interface dersig_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] sig_byte;
    logic       last_byte;

    modport source (output valid, output sig_byte, output last_byte, input ready);
    modport sink (input valid, input sig_byte, input last_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/core/dersig_verdict_if.sv
`default_nettype none
interface dersig_verdict_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink (input valid, input verdict, output ready);
endinterface
`default_nettype wire

>>> rtl/core/dersig_parse.sv
`default_nettype none
module dersig_parse #(
    parameter int MAX_SIG_BYTES  = 72,
    parameter int MAX_PART_BYTES = 33
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire dersig_pkg::t_byte_word i_word,
    output      dersig_pkg::t_verdict  o_verdict
);
    import dersig_pkg::*;

    localparam int BW = $clog2(MAX_SIG_BYTES + 2);
    localparam int PW = $clog2(MAX_PART_BYTES + 1);

    localparam logic [3:0] PH_HDR_TAG = 4'd0;
    localparam logic [3:0] PH_HDR_LEN = 4'd1;
    localparam logic [3:0] PH_R_TAG   = 4'd2;
    localparam logic [3:0] PH_R_LEN   = 4'd3;
    localparam logic [3:0] PH_R_BODY  = 4'd4;
    localparam logic [3:0] PH_S_TAG   = 4'd5;
    localparam logic [3:0] PH_S_LEN   = 4'd6;
    localparam logic [3:0] PH_S_BODY  = 4'd7;
    localparam logic [3:0] PH_DONE    = 4'd8;

    localparam logic [1:0] CMP_LT = 2'd0;
    localparam logic [1:0] CMP_EQ = 2'd1;
    localparam logic [1:0] CMP_GT = 2'd2;

    function automatic logic [1:0] cmp_step(input logic [1:0] st, input logic [7:0] a,
                                            input logic [7:0] b);
        if (st != CMP_EQ) begin
            return st;
        end
        if (a < b) begin
            return CMP_LT;
        end
        if (a > b) begin
            return CMP_GT;
        end
        return CMP_EQ;
    endfunction

    logic [BW-1:0] r_pos, n_pos;
    logic [7:0]    r_decl, n_decl;
    logic [3:0]    r_phase, n_phase;
    logic [PW-1:0] r_plen, n_plen;
    logic [PW-1:0] r_prem, n_prem;
    logic          r_lz, n_lz;
    logic [1:0]    r_rcmp, n_rcmp;
    logic [1:0]    r_scmp, n_scmp;
    logic [1:0]    r_hcmp, n_hcmp;
    logic          r_rej, n_rej;

    logic [7:0] w_b;
    logic       w_first;
    logic       w_second;
    logic       w_body_ok;
    logic       w_len_ok;
    logic [1:0] w_init;
    logic [7:0] w_nbyte;
    logic [7:0] w_hbyte;
    logic       w_is_s;

    assign w_b      = i_word.sig_byte;
    assign w_first  = (r_prem == r_plen);
    assign w_second = (PW'(r_prem + PW'(1)) == r_plen);
    assign w_nbyte  = order_byte(6'(r_prem));
    assign w_hbyte  = half_byte(6'(r_prem));
    assign w_len_ok = (w_b >= 8'd1) && (w_b <= 8'(MAX_PART_BYTES));
    assign w_init   = (w_b < 8'(ORDER_BYTES)) ? CMP_LT : CMP_EQ;
    assign w_is_s   = (r_phase == PH_S_BODY);

    always_comb begin
        w_body_ok = 1'b1;
        if (r_prem == '0) begin
            w_body_ok = 1'b0;
        end else if (w_first) begin
            if (w_b[7] || (w_b == 8'd0 && r_plen == PW'(1))) begin
                w_body_ok = 1'b0;
            end
        end else if (w_second && r_lz && !w_b[7]) begin
            w_body_ok = 1'b0;
        end
    end

    always_comb begin
        n_pos   = r_pos;
        n_decl  = r_decl;
        n_phase = r_phase;
        n_plen  = r_plen;
        n_prem  = r_prem;
        n_lz    = r_lz;
        n_rcmp  = r_rcmp;
        n_scmp  = r_scmp;
        n_hcmp  = r_hcmp;
        n_rej   = r_rej;
        o_verdict = VERDICT_REJECT;

        if (r_pos <= BW'(MAX_SIG_BYTES)) begin
            n_pos = BW'(r_pos + BW'(1));
        end
        if (n_pos > BW'(MAX_SIG_BYTES)) begin
            n_rej = 1'b1;
        end

        if (!n_rej) begin
            case (r_phase)
                PH_HDR_TAG: begin
                    if (w_b != TAG_SEQUENCE) n_rej = 1'b1;
                    else n_phase = PH_HDR_LEN;
                end
                PH_HDR_LEN: begin
                    n_decl  = w_b;
                    n_phase = PH_R_TAG;
                end
                PH_R_TAG, PH_S_TAG: begin
                    if (w_b != TAG_INTEGER) n_rej = 1'b1;
                    else n_phase = (r_phase == PH_R_TAG) ? PH_R_LEN : PH_S_LEN;
                end
                PH_R_LEN, PH_S_LEN: begin
                    if (!w_len_ok) begin
                        n_rej = 1'b1;
                    end else begin
                        n_plen = w_b[PW-1:0];
                        n_prem = w_b[PW-1:0];
                        n_lz   = 1'b0;
                        if (r_phase == PH_S_LEN) begin
                            n_scmp  = w_init;
                            n_hcmp  = w_init;
                            n_phase = PH_S_BODY;
                        end else begin
                            n_rcmp  = w_init;
                            n_phase = PH_R_BODY;
                        end
                    end
                end
                PH_R_BODY, PH_S_BODY: begin
                    if (!w_body_ok) begin
                        n_rej = 1'b1;
                    end else begin
                        if (w_first && w_b == 8'd0) begin
                            n_lz = 1'b1;
                        end
                        if (w_is_s) begin
                            n_scmp = cmp_step(r_scmp, w_b, w_nbyte);
                            n_hcmp = cmp_step(r_hcmp, w_b, w_hbyte);
                        end else begin
                            n_rcmp = cmp_step(r_rcmp, w_b, w_nbyte);
                        end
                        n_prem = PW'(r_prem - PW'(1));
                        if (r_prem == PW'(1)) begin
                            n_phase = w_is_s ? PH_DONE : PH_S_TAG;
                        end
                    end
                end
                default: begin
                    n_rej = 1'b1;
                end
            endcase
        end

        if (!n_rej && n_phase == PH_DONE
                && n_pos >= BW'(MIN_SIG_BYTES) && n_pos <= BW'(MAX_SIG_BYTES)
                && (9'(n_decl) + 9'd2) == 9'(n_pos)
                && n_rcmp == CMP_LT && n_scmp == CMP_LT) begin
            o_verdict = (n_hcmp == CMP_GT) ? VERDICT_HIGH_S : VERDICT_LOW_S;
        end

        if (i_word.last_byte) begin
            n_pos   = '0;
            n_decl  = '0;
            n_phase = PH_HDR_TAG;
            n_plen  = '0;
            n_prem  = '0;
            n_lz    = 1'b0;
            n_rcmp  = CMP_EQ;
            n_scmp  = CMP_EQ;
            n_hcmp  = CMP_EQ;
            n_rej   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_decl  <= '0;
            r_phase <= PH_HDR_TAG;
            r_plen  <= '0;
            r_prem  <= '0;
            r_lz    <= 1'b0;
            r_rcmp  <= CMP_EQ;
            r_scmp  <= CMP_EQ;
            r_hcmp  <= CMP_EQ;
            r_rej   <= 1'b0;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_decl  <= n_decl;
            r_phase <= n_phase;
            r_plen  <= n_plen;
            r_prem  <= n_prem;
            r_lz    <= n_lz;
            r_rcmp  <= n_rcmp;
            r_scmp  <= n_scmp;
            r_hcmp  <= n_hcmp;
            r_rej   <= n_rej;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/der_ecdsa_signature_canonical_check.sv
// A final byte is registered at the input, then its verdict in the output register.
// Throughput: one byte per cycle; the next signature may follow its final byte at once.
// A stalled output holds only the final byte of the next signature; other bytes keep flowing.
// Reset: synchronous, active low; parser returns to the header tag, both registers empty.
`default_nettype none
module der_ecdsa_signature_canonical_check #(
    parameter int MAX_SIG_BYTES  = 72,
    parameter int MAX_PART_BYTES = 33
) (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    dersig_byte_if.sink         i_byte,
    dersig_verdict_if.source    o_verdict
);
    import dersig_pkg::*;

    logic       r_in_v, n_in_v;
    t_byte_word r_in;
    logic       r_out_v, n_out_v;
    t_verdict   r_verdict;
    t_verdict   w_verdict;
    logic       w_step;
    logic       w_take;

    assign w_step = r_in_v && (!r_in.last_byte || !r_out_v || o_verdict.ready);
    assign w_take = i_byte.valid && i_byte.ready;

    assign i_byte.ready      = !r_in_v || w_step;
    assign o_verdict.valid   = r_out_v;
    assign o_verdict.verdict = r_verdict;

    dersig_parse #(
        .MAX_SIG_BYTES  (MAX_SIG_BYTES),
        .MAX_PART_BYTES (MAX_PART_BYTES)
    ) u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_word    (r_in),
        .o_verdict (w_verdict)
    );

    always_comb begin
        n_in_v = w_take ? 1'b1 : (w_step ? 1'b0 : r_in_v);
        n_out_v = r_out_v;
        if (o_verdict.ready) begin
            n_out_v = 1'b0;
        end
        if (w_step && r_in.last_byte) begin
            n_out_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_in_v  <= n_in_v;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in.sig_byte  <= i_byte.sig_byte;
            r_in.last_byte <= i_byte.last_byte;
        end
        if (w_step && r_in.last_byte) begin
            r_verdict <= w_verdict;
        end
    end

    a_mid_byte_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && !r_in.last_byte) |-> w_step)
        else $error("non-final byte stalled");

    a_final_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in.last_byte) |=> r_out_v)
        else $error("final byte produced no verdict word");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_verdict == VERDICT_REJECT || r_verdict == VERDICT_HIGH_S
                     || r_verdict == VERDICT_LOW_S))
        else $error("verdict code out of range");

endmodule
`default_nettype wire

>>> tb/der_ecdsa_signature_canonical_check_checker.sv
`default_nettype none
module der_ecdsa_signature_canonical_check_checker #(
    parameter int MAX_SIG_BYTES  = 72,
    parameter int MAX_PART_BYTES = 33
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dersig_byte_if      byte_mon,
    dersig_verdict_if   verdict_mon,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import dersig_pkg::*;

    typedef enum logic [3:0] {
        ST_SEQ_TAG, ST_SEQ_LEN, ST_R_TAG, ST_R_LEN, ST_R_BODY,
        ST_S_TAG, ST_S_LEN, ST_S_BODY, ST_DONE
    } t_parse_state;

    typedef enum logic [1:0] {MAG_BELOW, MAG_EQUAL, MAG_ABOVE} t_mag;

    logic [6:0]   byte_count;
    logic [7:0]   seq_len;
    t_parse_state parse_st;
    logic [5:0]   int_len;
    logic [5:0]   int_left;
    logic         lead_zero;
    t_mag         r_mag;
    t_mag         s_mag;
    t_mag         s_half_mag;
    logic         malformed;
    t_verdict     verdict_q[$];
    t_verdict     want;
    int           fail_count = 0;

    function automatic logic [7:0] curve_byte(input int idx, input bit half);
        logic [255:0] bound;
        bound = half ? HALF_N : ORDER_N;
        if (idx < 0 || idx >= ORDER_BYTES) begin
            return 8'h00;
        end
        return bound[255 - 8 * idx -: 8];
    endfunction

    function automatic t_mag mag_step(input t_mag st, input logic [7:0] a,
                                      input logic [7:0] b);
        if (st != MAG_EQUAL) begin
            return st;
        end
        if (a < b) begin
            return MAG_BELOW;
        end
        if (a > b) begin
            return MAG_ABOVE;
        end
        return MAG_EQUAL;
    endfunction

    task automatic clear_parser();
        byte_count = '0;
        seq_len    = '0;
        parse_st   = ST_SEQ_TAG;
        int_len    = '0;
        int_left   = '0;
        lead_zero  = 1'b0;
        r_mag      = MAG_EQUAL;
        s_mag      = MAG_EQUAL;
        s_half_mag = MAG_EQUAL;
        malformed  = 1'b0;
    endtask

    task automatic take_int_len(input logic [7:0] b, input bit is_s);
        t_mag first_mag;
        if (b < 8'd1 || b > 8'(MAX_PART_BYTES)) begin
            malformed = 1'b1;
            return;
        end
        int_len   = b[5:0];
        int_left  = b[5:0];
        lead_zero = 1'b0;
        first_mag = (b < 8'(ORDER_BYTES)) ? MAG_BELOW : MAG_EQUAL;
        if (is_s) begin
            s_mag      = first_mag;
            s_half_mag = first_mag;
            parse_st   = ST_S_BODY;
        end else begin
            r_mag    = first_mag;
            parse_st = ST_R_BODY;
        end
    endtask

    task automatic take_int_body(input logic [7:0] b, input bit is_s);
        int pos;
        int idx;
        pos = int'(int_len) - int'(int_left);
        idx = ORDER_BYTES - int'(int_len) + pos;
        if (pos == 0 && (b[7] || (b == 8'h00 && int_len == 6'd1))) begin
            malformed = 1'b1;
            return;
        end
        if (pos == 0 && b == 8'h00) begin
            lead_zero = 1'b1;
        end
        if (pos == 1 && lead_zero && !b[7]) begin
            malformed = 1'b1;
            return;
        end
        if (is_s) begin
            s_mag      = mag_step(s_mag, b, curve_byte(idx, 1'b0));
            s_half_mag = mag_step(s_half_mag, b, curve_byte(idx, 1'b1));
        end else begin
            r_mag = mag_step(r_mag, b, curve_byte(idx, 1'b0));
        end
        int_left = int_left - 6'd1;
        if (int_left == 6'd0) begin
            parse_st = is_s ? ST_DONE : ST_S_TAG;
        end
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic last);
        t_verdict outcome;
        if (byte_count <= 7'(MAX_SIG_BYTES)) begin
            byte_count = byte_count + 7'd1;
        end
        if (byte_count > 7'(MAX_SIG_BYTES)) begin
            malformed = 1'b1;
        end
        if (!malformed) begin
            case (parse_st)
                ST_SEQ_TAG: begin
                    if (b != TAG_SEQUENCE) malformed = 1'b1;
                    else parse_st = ST_SEQ_LEN;
                end
                ST_SEQ_LEN: begin
                    seq_len  = b;
                    parse_st = ST_R_TAG;
                end
                ST_R_TAG: begin
                    if (b != TAG_INTEGER) malformed = 1'b1;
                    else parse_st = ST_R_LEN;
                end
                ST_R_LEN:  take_int_len(b, 1'b0);
                ST_R_BODY: take_int_body(b, 1'b0);
                ST_S_TAG: begin
                    if (b != TAG_INTEGER) malformed = 1'b1;
                    else parse_st = ST_S_LEN;
                end
                ST_S_LEN:  take_int_len(b, 1'b1);
                ST_S_BODY: take_int_body(b, 1'b1);
                default:   malformed = 1'b1;
            endcase
        end
        if (last) begin
            outcome = VERDICT_REJECT;
            if (!malformed && parse_st == ST_DONE
                    && byte_count >= 7'(MIN_SIG_BYTES)
                    && byte_count <= 7'(MAX_SIG_BYTES)
                    && {1'b0, seq_len} + 9'd2 == {2'b00, byte_count}
                    && r_mag == MAG_BELOW && s_mag == MAG_BELOW) begin
                outcome = (s_half_mag == MAG_ABOVE) ? VERDICT_HIGH_S : VERDICT_LOW_S;
            end
            verdict_q.push_back(outcome);
            clear_parser();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            verdict_q.delete();
        end else begin
            if (byte_mon.valid && byte_mon.ready) begin
                absorb_byte(byte_mon.sig_byte, byte_mon.last_byte);
            end
            if (verdict_mon.valid && verdict_mon.ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: verdict mismatch, expected none, got %0d",
                             $time, verdict_mon.verdict);
                    fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (verdict_mon.verdict !== want) begin
                        $display("%0t: verdict mismatch, expected %0d, got %0d",
                                 $time, want, verdict_mon.verdict);
                        fail_count++;
                    end
                end
            end
        end
        o_pending    <= verdict_q.size();
        o_fail_count <= fail_count;
    end

endmodule
`default_nettype wire

>>> tb/der_ecdsa_signature_canonical_check_tb.sv
`default_nettype none
module der_ecdsa_signature_canonical_check_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dersig_pkg::*;

    localparam int MAX_PART_BYTES  = 33;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int HOLD_CYCLES     = 300;

    localparam int FLAW_NOISE   = 0;
    localparam int FLAW_PAD     = 1;
    localparam int FLAW_NEG     = 2;
    localparam int FLAW_INT_LEN = 3;
    localparam int FLAW_FLIP    = 4;
    localparam int FLAW_CUT     = 5;
    localparam int FLAW_TAIL    = 6;
    localparam int FLAW_LONG    = 7;
    localparam int FLAW_SEQ_LEN = 8;
    localparam int FLAW_TAG     = 9;
    localparam int FLAW_RANGE   = 24;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    bit hold_request   = 1'b0;
    int bytes_sent;
    int fail_count;
    int pending;

    logic [7:0] frame_q[$];

    always #1 i_clk = ~i_clk;

    dersig_byte_if    byte_bus();
    dersig_verdict_if verdict_bus();

    der_ecdsa_signature_canonical_check dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (byte_bus),
        .o_verdict (verdict_bus)
    );

    der_ecdsa_signature_canonical_check_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .byte_mon     (byte_bus),
        .verdict_mon  (verdict_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic logic [255:0] pick_value();
        logic [255:0] v;
        v = {$urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(19))
            0: v = ORDER_N - 256'd1;
            1: v = ORDER_N;
            2: v = ORDER_N + 256'($urandom_range(1, 3));
            3: v = HALF_N;
            4: v = HALF_N + 256'd1;
            5: v = HALF_N - 256'($urandom_range(1, 255));
            6: v = ORDER_N - 256'($urandom_range(2, 65535));
            7: v = '1;
            8, 9, 10, 11, 12, 13, 14, 15: begin
                v = v >> (8 * $urandom_range(24, 31) + $urandom_range(0, 7));
            end
            16, 17: v = v >> $urandom_range(255);
            18: v = {ORDER_N[255:128], v[127:0]};
            default: v = {HALF_N[255:64], v[63:0]};
        endcase
        return v;
    endfunction

    function automatic void append_integer(input logic [255:0] v, input bit pad,
                                           input bit neg, input bit bad_len);
        int top;
        int len_at;
        top = 31;
        while (top > 0 && v[top * 8 +: 8] == 8'h00) begin
            top--;
        end
        frame_q.push_back(TAG_INTEGER);
        len_at = frame_q.size();
        frame_q.push_back(8'h00);
        if (v[top * 8 + 7] && !neg) begin
            frame_q.push_back(8'h00);
        end
        if (pad) begin
            frame_q.push_back(8'h00);
        end
        for (int k = top; k >= 0; k--) begin
            frame_q.push_back(v[k * 8 +: 8]);
        end
        if (neg && !v[top * 8 + 7]) begin
            frame_q[len_at + 1] = frame_q[len_at + 1] | 8'h80;
        end
        if (bad_len) begin
            frame_q[len_at] = $urandom_range(1) ? 8'h00
                                                : 8'($urandom_range(MAX_PART_BYTES + 1, 255));
        end else begin
            frame_q[len_at] = 8'(frame_q.size() - len_at - 1);
        end
    endfunction

    function automatic void build_frame();
        int unsigned flaw;
        int unsigned which;
        int pos;
        int target;
        frame_q.delete();
        flaw  = $urandom_range(FLAW_RANGE);
        which = $urandom_range(1);
        if (flaw == FLAW_NOISE) begin
            repeat ($urandom_range(1, 80)) frame_q.push_back(8'($urandom));
            if ($urandom_range(1)) frame_q[0] = TAG_SEQUENCE;
            return;
        end
        frame_q.push_back(TAG_SEQUENCE);
        frame_q.push_back(8'h00);
        append_integer(pick_value(), flaw == FLAW_PAD && which == 0,
                       flaw == FLAW_NEG && which == 0, flaw == FLAW_INT_LEN && which == 0);
        append_integer(pick_value(), flaw == FLAW_PAD && which == 1,
                       flaw == FLAW_NEG && which == 1, flaw == FLAW_INT_LEN && which == 1);
        frame_q[1] = 8'(frame_q.size() - 2);
        case (flaw)
            FLAW_FLIP: begin
                pos = $urandom_range(frame_q.size() - 1);
                frame_q[pos] = frame_q[pos] ^ 8'($urandom_range(1, 255));
            end
            FLAW_CUT: begin
                target = $urandom_range(1, frame_q.size() - 1);
                while (frame_q.size() > target) void'(frame_q.pop_back());
            end
            FLAW_TAIL: begin
                repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
                if ($urandom_range(1)) frame_q[1] = 8'(frame_q.size() - 2);
            end
            FLAW_LONG: begin
                target = 73 + $urandom_range(7);
                while (frame_q.size() < target) frame_q.push_back(8'($urandom));
                frame_q[1] = 8'(frame_q.size() - 2);
            end
            FLAW_SEQ_LEN: frame_q[1] = frame_q[1] ^ 8'($urandom_range(1, 255));
            FLAW_TAG: begin
                case ($urandom_range(2))
                    0: pos = 0;
                    1: pos = 2;
                    default: pos = 4 + frame_q[3];
                endcase
                frame_q[pos] = frame_q[pos] ^ 8'($urandom_range(1, 255));
            end
            default: ;
        endcase
    endfunction

    task automatic put_word(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            byte_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_bus.valid     <= 1'b1;
        byte_bus.sig_byte  <= b;
        byte_bus.last_byte <= last;
        do @(posedge i_clk); while (!byte_bus.ready);
    endtask

    task automatic send_frame();
        for (int k = 0; k < frame_q.size(); k++) begin
            put_word(frame_q[k], k == frame_q.size() - 1);
        end
        bytes_sent += frame_q.size();
    endtask

    initial begin
        verdict_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                verdict_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            verdict_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin
        byte_bus.valid     = 1'b0;
        byte_bus.sig_byte  = 8'h00;
        byte_bus.last_byte = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        frame_q = '{8'h00};
        send_frame();
        frame_q = '{8'hFF};
        send_frame();
        frame_q = '{TAG_SEQUENCE, 8'h06, TAG_INTEGER, 8'h01, 8'h01,
                    TAG_INTEGER, 8'h01, 8'h01};
        send_frame();
        frame_q = '{TAG_SEQUENCE, 8'h07, TAG_INTEGER, 8'h01, 8'h7F,
                    TAG_INTEGER, 8'h01, 8'h7F, 8'h00};
        send_frame();

        for (int phase_no = 0; phase_no < 4; phase_no++) begin
            case (phase_no)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                    hold_request   = 1'b1;
                end
                1: begin
                    src_idle_pct   = 77;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 77;
                end
                default: begin
                    src_idle_pct   = 22;
                    sink_stall_pct = 22;
                end
            endcase
            bytes_sent = 0;
            while (bytes_sent < ITEMS_PER_PHASE) begin
                build_frame();
                send_frame();
            end
        end

        // drain
        byte_bus.valid <= 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("der_ecdsa_signature_canonical_check_tb OK");
        end else begin
            $display("der_ecdsa_signature_canonical_check_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("der_ecdsa_signature_canonical_check_tb NOT OK");
        $finish;
    end

endmodule
`default_nettype wire

>>> files.f
rtl/core/dersig_pkg.sv
rtl/core/dersig_byte_if.sv
rtl/core/dersig_verdict_if.sv
rtl/core/dersig_parse.sv
rtl/core/der_ecdsa_signature_canonical_check.sv
tb/der_ecdsa_signature_canonical_check_checker.sv
tb/der_ecdsa_signature_canonical_check_tb.sv
